[rtl/assert_macros.svh]
// Shared assertion macros for the projection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, inactive while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/cpp_pkg.sv]
`default_nettype none
package cpp_pkg;

    // coordinate width (Q.4) and derived arithmetic widths
    localparam int CW    = 20;
    localparam int RW    = CW + 1;        // point minus origin
    localparam int AW    = 16;            // axis component, Q2.14
    localparam int PW    = RW + AW;       // one product
    localparam int SW    = PW + 2;        // sum of three products
    localparam int FRAC  = 14;
    localparam int CAMW  = SW - FRAC;     // camera value, Q.4
    localparam int HW    = 12;            // half viewport size
    localparam int SCW   = 16;            // projection scale
    localparam int NP    = HW + 1 + CAMW; // half * camera value
    localparam int DENW  = SCW + 1 + CAMW;// scale * depth
    localparam int NUMW  = NP + 12;       // numerator magnitude, times 2^12
    localparam int QW    = 18;            // quotient bits kept
    localparam int QBW   = $clog2(QW);
    localparam int TW    = DENW + QW;
    localparam int RSW   = QW + 3;
    localparam int PRE   = 6;             // stages ahead of the divider
    localparam int STG   = PRE + QW;      // stages up to divider output
    localparam int ROUND_HALF = 8192;

    localparam logic signed [CAMW-1:0] DEPTH_MAX = CAMW'((1 << (CW - 1)) - 1);
    localparam logic signed [CAMW-1:0] DEPTH_MIN = -DEPTH_MAX - CAMW'(1);

    localparam logic [59:0] ORIGIN_RST  = 60'd0;
    localparam logic [47:0] RIGHT_RST   = 48'h0000_0000_4000;
    localparam logic [47:0] UP_RST      = 48'h0000_4000_0000;
    localparam logic [47:0] FWD_RST     = 48'h4000_0000_0000;
    localparam logic [23:0] HALF_RST    = 24'h21C3C0;
    localparam logic [31:0] SCALE_RST   = 32'h1000_1000;
    localparam logic [18:0] NEAR_RST    = 19'd24;

    typedef enum logic [2:0] {
        CFG_ORIGIN  = 3'd0,
        CFG_RIGHT   = 3'd1,
        CFG_UP      = 3'd2,
        CFG_FORWARD = 3'd3,
        CFG_HALF    = 3'd4,
        CFG_SCALES  = 3'd5,
        CFG_NEAR    = 3'd6
    } t_cfg_idx;

    // one division lane: remainder, divisor, quotient and flags
    typedef struct packed {
        logic [NUMW-1:0] rem;
        logic [DENW-1:0] den;
        logic [QW-1:0]   q;
        logic            neg;
        logic            sat;
        logic            nz;
    } t_lane;

    typedef struct packed {
        t_lane                lx;
        t_lane                ly;
        logic signed [CW-1:0] depth;
        logic                 vis;
    } t_item;

    typedef struct packed {
        logic signed [15:0]   screen_x;
        logic signed [15:0]   screen_y;
        logic signed [CW-1:0] depth;
        logic                 visible;
    } t_res;

endpackage
`default_nettype wire

[rtl/cpp_in_if.sv]
`default_nettype none
interface cpp_in_if import cpp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface
`default_nettype wire

[rtl/cpp_out_if.sv]
`default_nettype none
interface cpp_out_if import cpp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   screen_x;
    logic signed [15:0]   screen_y;
    logic signed [CW-1:0] depth;
    logic                 visible;

    modport source (output valid, screen_x, screen_y, depth, visible, input ready);
    modport sink   (input valid, screen_x, screen_y, depth, visible, output ready);
endinterface
`default_nettype wire

[rtl/camera_point_projection.sv]
// A point accepted on the input passes through 24 pipe stages, then the output
// register, before it is presented on the result channel. 24 compute stages run on
// a single shared advance, taking one point per cycle while the skid is empty.
// The 18-stage divider (one quotient bit per stage) sets the depth of the pipe.
// Reset (synchronous, active low) empties the pipe and loads the default camera.
`default_nettype none
`include "assert_macros.svh"
module camera_point_projection import cpp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [59:0] i_cfg_data,
    cpp_in_if.sink           i_pt,
    cpp_out_if.source        o_proj
);

    // ------------------------------------------------------------------
    // Configuration registers. They are to be written only while the block is idle
    // (the block does not enforce this), so every stage reads them directly.
    // ------------------------------------------------------------------
    logic [59:0] r_origin;
    logic [47:0] r_axis [3];   // right, up, forward
    logic [23:0] r_half;
    logic [31:0] r_scale;
    logic [18:0] r_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= ORIGIN_RST;
            r_axis[0] <= RIGHT_RST;
            r_axis[1] <= UP_RST;
            r_axis[2] <= FWD_RST;
            r_half   <= HALF_RST;
            r_scale  <= SCALE_RST;
            r_near   <= NEAR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN:  r_origin  <= i_cfg_data;
                CFG_RIGHT:   r_axis[0] <= i_cfg_data[47:0];
                CFG_UP:      r_axis[1] <= i_cfg_data[47:0];
                CFG_FORWARD: r_axis[2] <= i_cfg_data[47:0];
                CFG_HALF:    r_half    <= i_cfg_data[23:0];
                CFG_SCALES:  r_scale   <= i_cfg_data[31:0];
                CFG_NEAR:    r_near    <= i_cfg_data[18:0];
                default: ;   // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The whole pipe advances on one enable. A skid register
    // behind the output register catches the one request that is in flight
    // when the sink stalls; the enable is simply "skid empty", so it comes
    // from a flop and the pipe keeps taking points while a result waits.
    // ------------------------------------------------------------------
    logic       w_en;
    logic       r_v [STG];
    logic       r_o_v, r_s_v;
    t_res       r_o, r_s, w_res;

    assign w_en       = !r_s_v;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STG; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_pt.valid;
            for (int k = 1; k < STG; k++) r_v[k] <= r_v[k-1];
        end
    end

    // Stage 1: offset from the camera origin (exact).
    logic signed [RW-1:0] r_rel [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rel[0] <= RW'(i_pt.point_x) - RW'($signed(r_origin[0 +: CW]));
            r_rel[1] <= RW'(i_pt.point_y) - RW'($signed(r_origin[CW +: CW]));
            r_rel[2] <= RW'(i_pt.point_z) - RW'($signed(r_origin[2*CW +: CW]));
        end
    end

    // Stage 2: nine products, offset component times axis component.
    logic signed [PW-1:0] r_prod [3][3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[a][k] <= PW'(r_rel[k]) * PW'($signed(r_axis[a][AW*k +: AW]));
                end
            end
        end
    end

    // Stage 3: sum and round Q.18 to Q.4, halves toward plus infinity.
    // Dropping the low bits of a two's complement value is a floor shift.
    logic signed [CAMW-1:0] r_cam [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_cam[a] <= CAMW'((SW'(r_prod[a][0]) + SW'(r_prod[a][1]) + SW'(r_prod[a][2])
                                   + SW'(ROUND_HALF)) >>> FRAC);
            end
        end
    end

    // Stage 4: numerators (half times camera value) and denominators
    // (scale times depth); depth saturation and the visibility test.
    logic signed [NP-1:0]   r_nx, r_ny;
    logic signed [DENW-1:0] r_dx, r_dy;
    logic signed [CW-1:0]   r_depth4;
    logic                   r_vis4;
    logic signed [CW-1:0]   w_dsat;

    always_comb begin
        if (r_cam[2] > DEPTH_MAX)      w_dsat = CW'(DEPTH_MAX);
        else if (r_cam[2] < DEPTH_MIN) w_dsat = CW'(DEPTH_MIN);
        else                           w_dsat = r_cam[2][CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx     <= NP'($signed({1'b0, r_half[11:0]}))  * NP'(r_cam[0]);
            r_ny     <= NP'($signed({1'b0, r_half[23:12]})) * NP'(r_cam[1]);
            r_dx     <= DENW'($signed({1'b0, r_scale[15:0]}))  * DENW'(r_cam[2]);
            r_dy     <= DENW'($signed({1'b0, r_scale[31:16]})) * DENW'(r_cam[2]);
            r_depth4 <= w_dsat;
            r_vis4   <= (r_cam[2] != '0) && (r_cam[2] >= $signed(CAMW'(r_near)));
        end
    end

    // Stage 5: magnitudes and the sign of each quotient. The vertical term
    // is subtracted, so its numerator sign is flipped. With a zero
    // denominator the sign is that of the numerator alone.
    t_lane                r_l5x, r_l5y;
    logic signed [CW-1:0] r_depth5;
    logic                 r_vis5;
    logic                 w_nnx, w_nny;

    assign w_nnx = r_nx < 0;
    assign w_nny = r_ny > 0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l5x.rem <= {(w_nnx ? NP'(-r_nx) : NP'(r_nx)), 12'd0};
            r_l5x.den <= (r_dx < 0) ? DENW'(-r_dx) : DENW'(r_dx);
            r_l5x.q   <= '0;
            r_l5x.neg <= (r_dx == 0) ? w_nnx : (w_nnx ^ (r_dx < 0));
            r_l5x.sat <= 1'b0;
            r_l5x.nz  <= r_nx != 0;
            r_l5y.rem <= {((r_ny < 0) ? NP'(-r_ny) : NP'(r_ny)), 12'd0};
            r_l5y.den <= (r_dy < 0) ? DENW'(-r_dy) : DENW'(r_dy);
            r_l5y.q   <= '0;
            r_l5y.neg <= (r_dy == 0) ? w_nny : (w_nny ^ (r_dy < 0));
            r_l5y.sat <= 1'b0;
            r_l5y.nz  <= r_ny != 0;
            r_depth5  <= r_depth4;
            r_vis5    <= r_vis4;
        end
    end

    // Stage 6: flag quotients that cannot fit the kept bits. Such a term
    // swamps the half size, so the result saturates toward its sign; with a
    // zero numerator it is the half size. A zero denominator always lands here.
    t_item r_s6;
    t_item n_s6;
    always_comb begin
        n_s6        = {r_l5x, r_l5y, r_depth5, r_vis5};
        n_s6.lx.sat = {{(TW-NUMW){1'b0}}, r_l5x.rem} >= {r_l5x.den, {QW{1'b0}}};
        n_s6.ly.sat = {{(TW-NUMW){1'b0}}, r_l5y.rem} >= {r_l5y.den, {QW{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6 <= n_s6;
        end
    end

    // Stages 7 to 24: the divider.
    t_item w_dv;
    cpp_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_item (r_s6),
        .o_item (w_dv)
    );

    // Final combine: half plus or minus the quotient, saturated to 16 bits.
    function automatic logic signed [15:0] lane_out(t_lane l, logic [HW-1:0] h);
        logic signed [RSW-1:0] hs;
        logic signed [RSW-1:0] qs;
        logic signed [RSW-1:0] r;
        logic signed [15:0]    o;
        hs = $signed({{(RSW-HW){1'b0}}, h});
        qs = $signed({{(RSW-QW){1'b0}}, l.q});
        r  = l.neg ? hs - qs : hs + qs;
        if (l.sat) begin
            if (!l.nz)     o = $signed({4'd0, h});
            else if (l.neg) o = 16'sh8000;
            else           o = 16'sd32767;
        end else if (r > RSW'(32767)) begin
            o = 16'sd32767;
        end else if (r < -RSW'(32768)) begin
            o = 16'sh8000;
        end else begin
            o = r[15:0];
        end
        return o;
    endfunction

    always_comb begin
        w_res.screen_x = lane_out(w_dv.lx, r_half[11:0]);
        w_res.screen_y = lane_out(w_dv.ly, r_half[23:12]);
        w_res.depth    = w_dv.depth;
        w_res.visible  = w_dv.vis;
    end

    // Output register and skid. Take the skid first so order holds.
    logic w_pv;
    assign w_pv = r_v[STG-1] && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (!r_o_v || o_proj.ready) begin
            r_o_v <= r_s_v || w_pv;
            r_s_v <= 1'b0;
        end else if (w_pv) begin
            r_s_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_v || o_proj.ready) begin
            r_o <= r_s_v ? r_s : w_res;
        end else if (w_pv) begin
            r_s <= w_res;
        end
    end

    assign o_proj.valid    = r_o_v;
    assign o_proj.screen_x = r_o.screen_x;
    assign o_proj.screen_y = r_o.screen_y;
    assign o_proj.depth    = r_o.depth;
    assign o_proj.visible  = r_o.visible;

    // A full skid always sits behind a full output register.
    `ASSERT_CLK(a_skid_behind_out, r_s_v |-> r_o_v, "skid holds a request with output empty")
    // The skid fills only when the output was stalled.
    `ASSERT_CLK(a_skid_fill, $rose(r_s_v) |-> $past(r_o_v && !o_proj.ready),
        "skid filled without a stall")
    // An accepted point enters the first stage.
    `ASSERT_CLK(a_enter, (i_pt.valid && i_pt.ready) |=> r_v[0], "accepted point lost")
    // A visible point never has zero depth.
    `ASSERT_CLK(a_vis_depth, (r_o_v && r_o.visible) |-> (r_o.depth != '0),
        "visible point with zero depth")

endmodule
`default_nettype wire

[rtl/cpp_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per stage, both lanes side by side.
module cpp_div import cpp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_item i_item,
    output t_item      o_item
);

    t_item r_st [QW];

    function automatic t_lane lane_step(t_lane l, logic [QBW-1:0] b);
        logic [TW-1:0] sh;
        logic [TW-1:0] rm;
        logic [TW:0]   diff;
        t_lane         n;
        n    = l;
        sh   = {{QW{1'b0}}, l.den} << b;
        rm   = {{(TW-NUMW){1'b0}}, l.rem};
        diff = {1'b0, rm} - {1'b0, sh};
        if (!diff[TW]) begin
            n.rem  = diff[NUMW-1:0];
            n.q[b] = 1'b1;
        end
        return n;
    endfunction

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam logic [QBW-1:0] BIT = QBW'(QW - 1 - j);
        t_item n_st;
        always_comb begin
            n_st = (j == 0) ? i_item : r_st[(j == 0) ? 0 : j - 1];
            n_st.lx = lane_step(n_st.lx, BIT);
            n_st.ly = lane_step(n_st.ly, BIT);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j] <= n_st;
            end
        end
    end

    assign o_item = r_st[QW-1];

endmodule
`default_nettype wire
